[design/bflc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bflc_pkg
// Shared types and constants for the binary feature linear classifier.
// ----------------------------------------------------------------------------
package bflc_pkg;

    localparam int FEATURES_DEF    = 784;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int QUEUE_DEPTH     = 4;
    localparam int COUNT_W         = 20;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic signed [31:0] SUM_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SUM_MIN = 32'sh8000_0000;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_BEGIN = 2'd1;
    localparam logic [1:0] ACT_PIXEL = 2'd2;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_BEGIN,
        OP_PIXEL
    } op_kind_t;

    typedef struct packed {
        op_kind_t           kind;
        logic [9:0]         index;
        logic signed [15:0] weight;
        logic               label_bit;
        logic               nonzero;
        logic               last;
    } op_t;

endpackage
`default_nettype wire

[design/bflc_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bflc_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bflc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 784,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [WIDTH-1:0]  wdata,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule
`default_nettype wire

[design/bflc_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bflc_front
// Decodes input transfers into operations; queues valid ones, drops the rest.
// ----------------------------------------------------------------------------
module bflc_front #(
    parameter int FEATURES = bflc_pkg::FEATURES_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [1:0]          s_action,
    input  wire logic [9:0]          s_weight_index,
    input  wire logic signed [15:0]  s_weight_value,
    input  wire logic [7:0]          s_label,
    input  wire logic [7:0]          s_pixel,
    input  wire logic                s_last_pixel,
    output logic                     op_valid,
    input  wire logic                op_ready,
    output bflc_pkg::op_t            op
);
    import bflc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    op_t              queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    op_t  dec;
    logic keep;
    logic push;
    logic pop;

    always_comb begin
        dec.kind      = OP_PIXEL;
        dec.index     = s_weight_index;
        dec.weight    = s_weight_value;
        dec.label_bit = (s_label == 8'd1);
        dec.nonzero   = (s_pixel != 8'd0);
        dec.last      = s_last_pixel;
        keep          = 1'b0;
        case (s_action)
            ACT_WRITE: begin
                dec.kind = OP_WRITE;
                keep     = (32'(s_weight_index) < FEATURES);
            end
            ACT_BEGIN: begin
                dec.kind = OP_BEGIN;
                keep     = 1'b1;
            end
            ACT_PIXEL: begin
                dec.kind = OP_PIXEL;
                keep     = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push     = s_valid && s_ready && keep;
    assign op_valid = (count_reg != '0);
    assign pop      = op_valid && op_ready;
    assign op       = queue_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= dec;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

endmodule
`default_nettype wire

[design/bflc_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bflc_back
// Executes queued operations: weight store, accumulation and result output.
// ----------------------------------------------------------------------------
module bflc_back #(
    parameter int FEATURES    = bflc_pkg::FEATURES_DEF,
    parameter int WEIGHT_BITS = bflc_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           op_valid,
    output logic                op_ready,
    input  wire bflc_pkg::op_t  op,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic                m_prediction,
    output logic                m_label_bit,
    output logic                m_mismatch,
    output logic [19:0]         m_error_count,
    output logic [19:0]         m_sample_count
);
    import bflc_pkg::*;

    localparam int ADDR_W = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam int COL_W  = $clog2(FEATURES + 1);

    logic [COL_W-1:0] col_reg, col_next;

    logic     b_valid_reg, b_valid_next;
    op_kind_t b_kind_reg;
    logic     b_add_reg;
    logic     b_last_reg;
    logic     b_label_reg;

    logic signed [31:0] sum_reg, sum_next;
    logic               lbl_reg, lbl_next;
    logic [COUNT_W-1:0] err_reg, err_next;
    logic [COUNT_W-1:0] smp_reg, smp_next;

    logic               m_valid_reg, m_valid_next;
    logic               pred_reg, pred_next;
    logic               mlbl_reg, mlbl_next;
    logic               mis_reg, mis_next;
    logic [COUNT_W-1:0] merr_reg, merr_next;
    logic [COUNT_W-1:0] msmp_reg, msmp_next;

    logic                   stall;
    logic                   pop;
    logic                   col_ok;
    logic                   ram_en;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_addr;
    logic [WEIGHT_BITS-1:0] ram_wdata;
    logic [WEIGHT_BITS-1:0] ram_rdata;
    logic signed [31:0]     wext;
    logic [31:0]            widx32;
    logic signed [32:0]     sum_wide;
    logic signed [31:0]     sum_add;
    logic                   res_load;
    logic                   pred;
    logic                   mis;

    assign stall    = b_valid_reg && b_last_reg && (b_kind_reg == OP_PIXEL)
                      && m_valid_reg && !m_ready;
    assign op_ready = !stall;
    assign pop      = op_valid && !stall;
    assign col_ok   = (col_reg < COL_W'(FEATURES));

    assign wext      = 32'(op.weight);
    assign ram_wdata = wext[WEIGHT_BITS-1:0];
    assign widx32    = 32'(op.index);

    // front of the back pipe: memory access and column tracking
    always_comb begin
        ram_en   = 1'b0;
        ram_we   = 1'b0;
        ram_addr = col_reg[ADDR_W-1:0];
        col_next = col_reg;
        if (pop) begin
            case (op.kind)
                OP_WRITE: begin
                    ram_en   = 1'b1;
                    ram_we   = 1'b1;
                    ram_addr = widx32[ADDR_W-1:0];
                end
                OP_BEGIN: begin
                    col_next = '0;
                end
                OP_PIXEL: begin
                    ram_en = col_ok && op.nonzero;
                    if (op.last) begin
                        col_next = '0;
                    end else if (col_ok) begin
                        col_next = col_reg + 1'b1;
                    end
                end
                default: begin
                    col_next = col_reg;
                end
            endcase
        end
    end

    bflc_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (FEATURES),
        .ADDR_W(ADDR_W)
    ) u_weights (
        .aclk (aclk),
        .en   (ram_en),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign b_valid_next = stall ? b_valid_reg : pop;

    always_ff @(posedge aclk) begin
        if (!stall) begin
            b_kind_reg  <= op.kind;
            b_add_reg   <= col_ok && op.nonzero;
            b_last_reg  <= op.last;
            b_label_reg <= op.label_bit;
        end
    end

    // accumulate and finish
    assign sum_wide = 33'(sum_reg) + 33'(signed'(ram_rdata));
    always_comb begin
        if (sum_wide[32] != sum_wide[31]) begin
            sum_add = sum_wide[32] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_add = sum_wide[31:0];
        end
    end

    always_comb begin
        sum_next     = sum_reg;
        lbl_next     = lbl_reg;
        err_next     = err_reg;
        smp_next     = smp_reg;
        res_load     = 1'b0;
        pred         = 1'b0;
        mis          = 1'b0;
        if (b_valid_reg && !stall) begin
            case (b_kind_reg)
                OP_BEGIN: begin
                    sum_next = '0;
                    lbl_next = b_label_reg;
                end
                OP_PIXEL: begin
                    sum_next = b_add_reg ? sum_add : sum_reg;
                    if (b_last_reg) begin
                        res_load = 1'b1;
                        pred     = !sum_next[31];
                        mis      = (pred != lbl_reg);
                        if (mis && err_reg != COUNT_MAX) begin
                            err_next = err_reg + 1'b1;
                        end
                        if (smp_reg != COUNT_MAX) begin
                            smp_next = smp_reg + 1'b1;
                        end
                        sum_next = '0;
                    end
                end
                default: begin
                    sum_next = sum_reg;
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        pred_next    = pred_reg;
        mlbl_next    = mlbl_reg;
        mis_next     = mis_reg;
        merr_next    = merr_reg;
        msmp_next    = msmp_reg;
        if (res_load) begin
            m_valid_next = 1'b1;
            pred_next    = pred;
            mlbl_next    = lbl_reg;
            mis_next     = mis;
            merr_next    = err_next;
            msmp_next    = smp_next;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            b_valid_reg <= 1'b0;
            sum_reg     <= '0;
            lbl_reg     <= 1'b0;
            err_reg     <= '0;
            smp_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            col_reg     <= col_next;
            b_valid_reg <= b_valid_next;
            sum_reg     <= sum_next;
            lbl_reg     <= lbl_next;
            err_reg     <= err_next;
            smp_reg     <= smp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pred_reg <= pred_next;
        mlbl_reg <= mlbl_next;
        mis_reg  <= mis_next;
        merr_reg <= merr_next;
        msmp_reg <= msmp_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_prediction   = pred_reg;
    assign m_label_bit    = mlbl_reg;
    assign m_mismatch     = mis_reg;
    assign m_error_count  = merr_reg;
    assign m_sample_count = msmp_reg;

    a_stall_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        stall |-> m_valid_reg)
        else $error("stall without pending result");

    a_counts_order: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg <= smp_reg)
        else $error("error count above sample count");

    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= COL_W'(FEATURES))
        else $error("column counter beyond feature count");

    a_sum_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |=> (sum_reg == '0))
        else $error("sum not cleared after result");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        stall |=> $stable(b_valid_reg))
        else $error("stage moved during stall");

endmodule
`default_nettype wire

[design/binary_feature_linear_classifier_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_feature_linear_classifier_top
// Linear classifier over binarized pixels with saturating error statistics.
// Result path for the last pixel: queue pop with weight read, then the
//   result register. Throughput: one item per cycle, set by the single
//   weight RAM port, unless a last pixel waits on an unaccepted result.
// Reset clears sum, column, label bit, counts and queue; the weight store is
//   not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
module binary_feature_linear_classifier_top #(
    parameter int FEATURES    = bflc_pkg::FEATURES_DEF,
    parameter int WEIGHT_BITS = bflc_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_action,
    input  wire logic [9:0]         s_weight_index,
    input  wire logic signed [15:0] s_weight_value,
    input  wire logic [7:0]         s_label,
    input  wire logic [7:0]         s_pixel,
    input  wire logic               s_last_pixel,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_prediction,
    output logic                    m_label_bit,
    output logic                    m_mismatch,
    output logic [19:0]             m_error_count,
    output logic [19:0]             m_sample_count
);
    import bflc_pkg::*;

    op_t  op;
    logic op_valid;
    logic op_ready;

    bflc_front #(
        .FEATURES(FEATURES)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_weight_index(s_weight_index),
        .s_weight_value(s_weight_value),
        .s_label       (s_label),
        .s_pixel       (s_pixel),
        .s_last_pixel  (s_last_pixel),
        .op_valid      (op_valid),
        .op_ready      (op_ready),
        .op            (op)
    );

    bflc_back #(
        .FEATURES   (FEATURES),
        .WEIGHT_BITS(WEIGHT_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .op_valid      (op_valid),
        .op_ready      (op_ready),
        .op            (op),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_prediction  (m_prediction),
        .m_label_bit   (m_label_bit),
        .m_mismatch    (m_mismatch),
        .m_error_count (m_error_count),
        .m_sample_count(m_sample_count)
    );

endmodule
`default_nettype wire
